// File: rtl/core/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared types, widths, register indexes and pattern helpers of the
// region multi-stride prefetcher.
// ----------------------------------------------------------------------------
package rmsp_pkg;

  // default sizes of the top level
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int LINE_SHIFT_DEF    = 6;
  localparam int REGION_SHIFT_DEF  = 12;
  localparam int MAX_DEGREE_DEF    = 16;

  // fixed field widths
  localparam int ADDR_W     = 48;
  localparam int IDX_W      = 42;
  localparam int TS_W       = 32;
  localparam int ROOM_W     = 5;
  localparam int CNT_W      = 8;
  localparam int SENT_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_ONLY = 3'd5;

  // what the region lookup asks of the pattern engine
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_ALLOC  = 2'd2
  } act_t;

  typedef struct packed {
    logic [7:0] single_thr;
    logic [7:0] multi_thr;
    logic [5:0] start_dist;
    logic [4:0] degree;
    logic [5:0] distance;
    logic       single_only;
  } cfg_t;

  // one region's pattern record
  typedef struct packed {
    logic                       trained;
    logic                       check;
    logic                       two;
    logic                       cur;
    logic                       pcur;
    logic [IDX_W-1:0]           last;
    logic [1:0][IDX_W-1:0]      stride;
    logic [1:0][IDX_W-1:0]      trans;
    logic [1:0][CNT_W-1:0]      rep;
    logic [CNT_W-1:0]           count;
    logic [CNT_W-1:0]           recnt;
    logic [CNT_W-1:0]           pcount;
    logic [IDX_W-1:0]           ptr;
    logic [SENT_W-1:0]          sent;
  } ent_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == {CNT_W{1'b1}}) ? x : x + 1'b1;
  endfunction

  function automatic ent_t clear_pat(input ent_t e);
    ent_t r;
    r         = e;
    r.trained = 1'b0;
    r.check   = 1'b0;
    r.two     = 1'b0;
    r.cur     = 1'b0;
    r.stride  = '0;
    r.trans   = '0;
    r.rep     = '0;
    r.count   = '0;
    r.recnt   = '0;
    r.sent    = '0;
    return r;
  endfunction

  // one step of the prefetch walker along the pattern
  function automatic ent_t advance(input ent_t e);
    ent_t r;
    r = e;
    if (e.pcount == e.rep[e.pcur]) begin
      r.ptr    = e.ptr + e.trans[e.pcur];
      r.pcount = '0;
      r.pcur   = ~e.pcur;
    end else begin
      r.ptr    = e.ptr + e.stride[e.pcur];
      r.pcount = sat_inc(e.pcount);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/rmsp_region_table.sv
// ----------------------------------------------------------------------------
// rmsp_region_table
// Region tag and recency memory. Scans one entry per cycle for a tag match,
// the first free entry and the least recent entry, then writes back.
// ----------------------------------------------------------------------------
module rmsp_region_table #(
  parameter int ENTRIES = rmsp_pkg::TABLE_ENTRIES_DEF,
  parameter int TAG_W   = rmsp_pkg::ADDR_W - rmsp_pkg::REGION_SHIFT_DEF,
  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [TAG_W-1:0]         tag,
  input  logic [rmsp_pkg::TS_W-1:0] ts,
  input  logic                     hit,
  output logic                     done,
  output rmsp_pkg::act_t           act,
  output logic [IW-1:0]            idx
);
  import rmsp_pkg::*;

  logic [TAG_W+TS_W-1:0] tag_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid;

  logic                  busy;
  logic [IW:0]           rd_cnt;
  logic                  rd_v;
  logic [IW-1:0]         cmp_idx;
  logic [TAG_W+TS_W-1:0] rd_data;
  logic [TAG_W-1:0]      tag_q;
  logic [TS_W-1:0]       ts_q;
  logic                  hit_q;
  logic                  found, inv_found;
  logic [IW-1:0]         found_idx, inv_idx, min_idx;
  logic [TS_W-1:0]       min_rec;

  logic                  found_next, inv_found_next;
  logic [IW-1:0]         found_idx_next, inv_idx_next, min_idx_next;
  logic [TS_W-1:0]       min_rec_next;
  logic [TAG_W-1:0]      cur_tag;
  logic [TS_W-1:0]       cur_rec;
  logic                  issue;

  assign cur_tag = rd_data[TAG_W+TS_W-1:TS_W];
  assign cur_rec = rd_data[TS_W-1:0];
  assign issue   = busy && (rd_cnt < (IW+1)'(ENTRIES));

  // fold the entry just read into the running search
  always_comb begin
    found_next     = found;
    found_idx_next = found_idx;
    inv_found_next = inv_found;
    inv_idx_next   = inv_idx;
    min_rec_next   = min_rec;
    min_idx_next   = min_idx;
    if (rd_v) begin
      if (!found && valid[cmp_idx] && cur_tag == tag_q) begin
        found_next     = 1'b1;
        found_idx_next = cmp_idx;
      end
      if (!inv_found && !valid[cmp_idx]) begin
        inv_found_next = 1'b1;
        inv_idx_next   = cmp_idx;
      end
      if (cmp_idx == '0 || cur_rec < min_rec) begin
        min_rec_next = cur_rec;
        min_idx_next = cmp_idx;
      end
    end
  end

  // result on the last compared entry
  assign done = rd_v && (cmp_idx == IW'(ENTRIES - 1));
  always_comb begin
    if (found_next) begin
      act = ACT_UPDATE;
      idx = found_idx_next;
    end else if (hit_q) begin
      act = ACT_NONE;
      idx = found_idx_next;
    end else begin
      act = ACT_ALLOC;
      idx = inv_found_next ? inv_idx_next : min_idx_next;
    end
  end

  // tag memory: one read and one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= tag_mem[rd_cnt[IW-1:0]];
    end
    if (done && act != ACT_NONE) begin
      tag_mem[idx] <= {tag_q, ts_q};
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      rd_v  <= 1'b0;
      valid <= '0;
    end else begin
      rd_v <= issue;
      if (start) begin
        busy      <= 1'b1;
        rd_cnt    <= '0;
        tag_q     <= tag;
        ts_q      <= ts;
        hit_q     <= hit;
        found     <= 1'b0;
        inv_found <= 1'b0;
      end else begin
        if (issue) begin
          cmp_idx <= rd_cnt[IW-1:0];
          rd_cnt  <= rd_cnt + 1'b1;
        end
        found     <= found_next;
        found_idx <= found_idx_next;
        inv_found <= inv_found_next;
        inv_idx   <= inv_idx_next;
        min_rec   <= min_rec_next;
        min_idx   <= min_idx_next;
        if (done) begin
          busy <= 1'b0;
          if (act != ACT_NONE) begin
            valid[idx] <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/rmsp_engine.sv
// ----------------------------------------------------------------------------
// rmsp_engine
// Pattern memory with read-modify-write of one region record: training,
// start-distance walk and one prefetch emission per cycle while emit_ready holds.
// ----------------------------------------------------------------------------
module rmsp_engine #(
  parameter int ENTRIES    = rmsp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_DEGREE = rmsp_pkg::MAX_DEGREE_DEF,
  localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  rmsp_pkg::act_t              act,
  input  logic [IW-1:0]               idx,
  input  logic [rmsp_pkg::IDX_W-1:0]  line,
  input  logic [rmsp_pkg::ROOM_W-1:0] room,
  input  rmsp_pkg::cfg_t              cfg,
  input  logic                        emit_ready,
  output logic                        emit_valid,
  output logic [rmsp_pkg::IDX_W-1:0]  emit_line,
  output logic                        emit_last,
  output logic                        done
);
  import rmsp_pkg::*;

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_UPD  = 5'b00010,
    E_WALK = 5'b00100,
    E_EMIT = 5'b01000,
    E_WB   = 5'b10000
  } est_t;

  est_t              state;
  ent_t              ent_mem [ENTRIES];
  ent_t              ent_rd;
  ent_t              e_reg;
  act_t              act_q;
  logic [IW-1:0]     idx_q;
  logic [IDX_W-1:0]  line_q;
  logic [ROOM_W-1:0] room_q;
  logic [5:0]        walk_cnt;
  logic [7:0]        n_cnt;
  logic              adv_mode;

  ent_t              upd_e;
  logic              upd_walk, upd_emit, upd_mode;
  ent_t              nxt;
  logic [7:0]        n1;
  logic              more;
  logic [7:0]        lim;

  assign lim = (8'(cfg.degree) < 8'(MAX_DEGREE)) ? 8'(cfg.degree) : 8'(MAX_DEGREE);

  // record update on the lookup result
  always_comb begin
    ent_t             e;
    logic [IDX_W-1:0] st;
    logic [IDX_W-1:0] s;
    logic [47:0]      prod;
    logic             c;
    e        = ent_rd;
    st       = line_q - ent_rd.last;
    c        = ent_rd.cur;
    upd_walk = 1'b0;
    upd_emit = 1'b0;
    upd_mode = 1'b0;
    s        = '0;
    prod     = '0;
    if (act_q == ACT_ALLOC) begin
      e      = clear_pat(ent_rd);
      e.last = line_q;
    end else if (!ent_rd.trained) begin
      e.last = line_q;
      if (!e.check) begin
        if (e.stride[c] == '0) begin
          e.stride[c] = st;
          e.rep[c]    = 8'd1;
        end else if (e.stride[c] == st) begin
          e.rep[c] = sat_inc(e.rep[c]);
        end else if (cfg.single_only) begin
          e.stride[c] = st;
          e.rep[c]    = 8'd1;
        end else begin
          e.trans[c] = st;
          e.two      = 1'b1;
          e.cur      = ~c;
          if (c) begin
            e.check = 1'b1;
            e.count = '0;
            e.recnt = '0;
          end
        end
      end else begin
        if (st == e.stride[c] && e.count < e.rep[c]) begin
          e.recnt = sat_inc(e.recnt);
          e.count = sat_inc(e.count);
        end else if (st == e.trans[c] && e.count == e.rep[c]) begin
          e.recnt = sat_inc(e.recnt);
          e.count = '0;
          e.cur   = ~c;
        end else begin
          e = clear_pat(e);
        end
      end
      // single stride stream trained
      s    = e.stride[e.cur];
      prod = s * cfg.start_dist;
      if (e.rep[e.cur] >= cfg.single_thr) begin
        e.trained   = 1'b1;
        e.two       = 1'b0;
        e.cur       = 1'b0;
        e.stride[0] = s;
        e.ptr       = e.last + prod[IDX_W-1:0];
      end
      // two-stride pattern confirmed
      if (e.recnt >= cfg.multi_thr) begin
        e.trained = 1'b1;
        e.pcount  = e.count;
        e.pcur    = e.cur;
        e.ptr     = e.last;
        upd_walk  = (cfg.start_dist != '0);
      end
    end else begin
      e.last = line_q;
      if (e.sent != '0) begin
        e.sent = e.sent - 1'b1;
      end
      if (!e.two && st == e.stride[0]) begin
        upd_emit = 1'b1;
      end else if ((st == e.stride[c] && e.count < e.rep[c]) ||
                   (st == e.trans[c] && e.count == e.rep[c])) begin
        if (e.count == e.rep[c]) begin
          e.count = '0;
          e.cur   = ~c;
        end else begin
          e.count = sat_inc(e.count);
        end
        upd_emit = 1'b1;
        upd_mode = 1'b1;
      end else begin
        e = clear_pat(e);
      end
      upd_emit = upd_emit && (lim != '0) && (e.sent < SENT_W'(cfg.distance)) &&
                 (room_q != '0);
    end
    upd_e = e;
  end

  // one prefetch step
  always_comb begin
    nxt = adv_mode ? advance(e_reg) : e_reg;
    if (!adv_mode) begin
      nxt.ptr = e_reg.ptr + e_reg.stride[0];
    end
    nxt.sent = e_reg.sent + 1'b1;
    n1       = n_cnt + 1'b1;
    more     = (n1 < lim) && (nxt.sent < SENT_W'(cfg.distance)) && (n1 < 8'(room_q));
  end

  assign emit_valid = (state == E_EMIT);
  assign emit_line  = nxt.ptr;
  assign emit_last  = !more;
  assign done       = (state == E_WB);

  // pattern memory
  always_ff @(posedge clk) begin
    if (start) begin
      ent_rd <= ent_mem[idx];
    end
    if (state == E_WB) begin
      ent_mem[idx_q] <= e_reg;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      case (state)
        E_IDLE: begin
          if (start) begin
            act_q  <= act;
            idx_q  <= idx;
            line_q <= line;
            room_q <= room;
            state  <= E_UPD;
          end
        end
        E_UPD: begin
          e_reg    <= upd_e;
          adv_mode <= upd_mode;
          n_cnt    <= '0;
          walk_cnt <= cfg.start_dist;
          if (upd_walk) begin
            state <= E_WALK;
          end else if (upd_emit) begin
            state <= E_EMIT;
          end else begin
            state <= E_WB;
          end
        end
        E_WALK: begin
          e_reg    <= advance(e_reg);
          walk_cnt <= walk_cnt - 1'b1;
          if (walk_cnt == 6'd1) begin
            state <= E_WB;
          end
        end
        E_EMIT: begin
          if (emit_ready) begin
            e_reg <= nxt;
            n_cnt <= n1;
            if (!more) begin
              state <= E_WB;
            end
          end
        end
        E_WB: begin
          state <= E_IDLE;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/region_multi_stride_prefetcher.sv
// Timing: an access runs a region scan (one tag read per cycle), then, unless
// the lookup asks for nothing, an update step, a start_distance walk when a
// two-stride pattern trains, the prefetches (held while the output stalls)
// and a write-back. A new access is taken only once the previous one is
// through the tag memory scan and the pattern memory read-modify-write.
// Reset: synchronous; config registers to defaults, region valid bits cleared.
// ----------------------------------------------------------------------------
// region_multi_stride_prefetcher
// Region based multi-stride prefetcher: region lookup with LRU allocation
// and a two-state stride pattern per region that emits prefetch lines.
// ----------------------------------------------------------------------------
module region_multi_stride_prefetcher #(
  parameter int TABLE_ENTRIES = rmsp_pkg::TABLE_ENTRIES_DEF,
  parameter int LINE_SHIFT    = rmsp_pkg::LINE_SHIFT_DEF,
  parameter int REGION_SHIFT  = rmsp_pkg::REGION_SHIFT_DEF,
  parameter int MAX_DEGREE    = rmsp_pkg::MAX_DEGREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rmsp_pkg::ADDR_W-1:0]     line_address,
  input  logic                            was_hit,
  input  logic [rmsp_pkg::TS_W-1:0]       time_stamp,
  input  logic [rmsp_pkg::ROOM_W-1:0]     queue_room,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rmsp_pkg::IDX_W-1:0]      prefetch_line,
  output logic                            last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rmsp_pkg::*;

  localparam int TAG_W = ADDR_W - REGION_SHIFT;
  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_SCAN = 3'b010,
    T_ENG  = 3'b100
  } tst_t;

  tst_t              state;
  cfg_t              cfg;
  logic [IDX_W-1:0]  line_q;
  logic [ROOM_W-1:0] room_q;

  logic              in_xfer;
  logic              tbl_done;
  act_t              tbl_act;
  logic [IW-1:0]     tbl_idx;
  logic              eng_start, eng_done;
  logic              emit_valid, emit_ready, emit_last;
  logic [IDX_W-1:0]  emit_line;

  assign in_ready  = (state == T_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign eng_start = (state == T_SCAN) && tbl_done && (tbl_act != ACT_NONE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_thr  <= 8'd4;
      cfg.multi_thr   <= 8'd4;
      cfg.start_dist  <= 6'd4;
      cfg.degree      <= 5'd4;
      cfg.distance    <= 6'd16;
      cfg.single_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SINGLE_THR:  cfg.single_thr  <= cfg_data;
        REG_MULTI_THR:   cfg.multi_thr   <= cfg_data;
        REG_START_DIST:  cfg.start_dist  <= cfg_data[5:0];
        REG_DEGREE:      cfg.degree      <= cfg_data[4:0];
        REG_DISTANCE:    cfg.distance    <= cfg_data[5:0];
        REG_SINGLE_ONLY: cfg.single_only <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // access control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (in_xfer) begin
            state <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (tbl_done) begin
            state <= (tbl_act == ACT_NONE) ? T_IDLE : T_ENG;
          end
        end
        T_ENG: begin
          if (eng_done) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // access payload held for the engine
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      line_q <= IDX_W'(line_address >> LINE_SHIFT);
      room_q <= queue_room;
    end
  end

  rmsp_region_table #(
    .ENTRIES (TABLE_ENTRIES),
    .TAG_W   (TAG_W)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .tag   (TAG_W'(line_address >> REGION_SHIFT)),
    .ts    (time_stamp),
    .hit   (was_hit),
    .done  (tbl_done),
    .act   (tbl_act),
    .idx   (tbl_idx)
  );

  rmsp_engine #(
    .ENTRIES    (TABLE_ENTRIES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (eng_start),
    .act        (tbl_act),
    .idx        (tbl_idx),
    .line       (line_q),
    .room       (room_q),
    .cfg        (cfg),
    .emit_ready (emit_ready),
    .emit_valid (emit_valid),
    .emit_line  (emit_line),
    .emit_last  (emit_last),
    .done       (eng_done)
  );

  // output register
  assign emit_ready = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      prefetch_line <= emit_line;
      last_of_run   <= emit_last;
    end
  end

endmodule

// File: rtl/core/rmsp_checker.sv
// ----------------------------------------------------------------------------
// rmsp_checker
// Port-level checks of the prefetcher, bound to the top level.
// ----------------------------------------------------------------------------
module rmsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [rmsp_pkg::ADDR_W-1:0]     line_address,
  input logic                            was_hit,
  input logic [rmsp_pkg::TS_W-1:0]       time_stamp,
  input logic [rmsp_pkg::ROOM_W-1:0]     queue_room,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rmsp_pkg::IDX_W-1:0]      prefetch_line,
  input logic                            last_of_run,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled prefetch holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prefetch_line) && $stable(last_of_run))
    else $error("stalled prefetch changed");

  // an accepted access keeps the block busy through its scan
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("access accepted during scan");

  // new prefetches appear only while an access is in work
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("prefetch without access in work");

endmodule

bind region_multi_stride_prefetcher rmsp_checker u_rmsp_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the region multi-stride prefetcher. Cache accesses
// go in through a valid/ready port and are predicted by a scoreboard that
// keeps its own region table and stride patterns. Each prefetch transfer is
// compared in order against the predicted lines. Several register settings
// are run, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import rmsp_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] line;
    logic             last;
  } pf_t;

  // region table predictor and store of predicted prefetches
  class prefetch_scoreboard;
    logic [7:0]        single_thr, multi_thr;
    logic [5:0]        start_dist, distance;
    logic [4:0]        degree;
    logic              single_only;
    logic [35:0]       tags[16];
    bit                valid[16];
    logic [TS_W-1:0]   recency[16];
    ent_t              ent[16];
    pf_t               want[$];
    int                errors;

    function new();
      single_thr = 4; multi_thr = 4; start_dist = 4; degree = 4; distance = 16;
      single_only = 0; errors = 0;
      for (int i = 0; i < 16; i++) begin
        tags[i] = '0; valid[i] = 0; recency[i] = '0; ent[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SINGLE_THR:  single_thr = val;
        REG_MULTI_THR:   multi_thr = val;
        REG_START_DIST:  start_dist = val[5:0];
        REG_DEGREE:      degree = val[4:0];
        REG_DISTANCE:    distance = val[5:0];
        REG_SINGLE_ONLY: single_only = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] bump(logic [7:0] x);
      return (x == 8'hFF) ? x : x + 8'd1;
    endfunction

    function void wipe(inout ent_t e);
      e.trained = 0; e.check = 0; e.two = 0; e.cur = 0;
      e.stride = '0; e.trans = '0; e.rep = '0;
      e.count = '0; e.recnt = '0; e.sent = '0;
    endfunction

    // move the prefetch pointer one element along the two-state pattern
    function void walk(inout ent_t e, output logic [IDX_W-1:0] p);
      if (e.pcount == e.rep[e.pcur]) begin
        p = e.ptr + e.trans[e.pcur];
        e.pcount = '0;
        e.pcur = ~e.pcur;
      end else begin
        p = e.ptr + e.stride[e.pcur];
        e.pcount = bump(e.pcount);
      end
      e.ptr = p;
    endfunction

    function void note_access(logic [ADDR_W-1:0] addr, logic hit, logic [TS_W-1:0] ts,
                              logic [ROOM_W-1:0] room);
      logic [IDX_W-1:0] line, stride, s, p;
      logic [35:0] tag;
      int r, n, lim;
      logic c;
      ent_t e;
      pf_t run[$];
      line = addr[ADDR_W-1:6];
      tag = addr[ADDR_W-1:12];
      r = 16;
      n = 0;
      for (int i = 0; i < 16; i++)
        if (r == 16 && valid[i] && tags[i] == tag) r = i;
      // region miss: allocate unless the access hit
      if (r == 16) begin
        if (hit) return;
        for (int i = 0; i < 16; i++)
          if (r == 16 && !valid[i]) r = i;
        if (r == 16) begin
          r = 0;
          for (int i = 1; i < 16; i++)
            if (recency[i] < recency[r]) r = i;
        end
        tags[r] = tag; valid[r] = 1; recency[r] = ts;
        e = ent[r];
        wipe(e);
        e.last = line;
        ent[r] = e;
        return;
      end
      e = ent[r];
      stride = line - e.last;
      e.last = line;
      recency[r] = ts;
      if (!e.trained) begin
        // training of one or two strides
        c = e.cur;
        if (!e.check) begin
          if (e.stride[c] == 0) begin
            e.stride[c] = stride; e.rep[c] = 1;
          end else if (e.stride[c] == stride) begin
            e.rep[c] = bump(e.rep[c]);
          end else if (single_only) begin
            e.stride[c] = stride; e.rep[c] = 1;
          end else begin
            e.trans[c] = stride; e.two = 1; e.cur = ~e.cur;
            if (e.cur == 0) begin
              e.check = 1; e.count = 0; e.recnt = 0;
            end
          end
        end else begin
          if (stride == e.stride[c] && e.count < e.rep[c]) begin
            e.recnt = bump(e.recnt); e.count = bump(e.count);
          end else if (stride == e.trans[c] && e.count == e.rep[c]) begin
            e.recnt = bump(e.recnt); e.count = 0; e.cur = ~e.cur;
          end else begin
            wipe(e);
          end
        end
        if (e.rep[e.cur] >= single_thr) begin
          s = e.stride[e.cur];
          e.trained = 1; e.two = 0; e.cur = 0;
          e.stride[0] = s;
          e.ptr = e.last + s * start_dist;
        end
        if (e.recnt >= multi_thr) begin
          e.trained = 1; e.pcount = e.count; e.pcur = e.cur; e.ptr = e.last;
          for (int i = 0; i < start_dist; i++) walk(e, p);
        end
      end else begin
        // trained region: emit along the pattern
        lim = (degree < 16) ? degree : 16;
        c = e.cur;
        if (e.sent > 0) e.sent = e.sent - 1;
        if (!e.two && stride == e.stride[0]) begin
          for (int i = 0; i < lim && e.sent < distance; i++) begin
            if (n >= room) break;
            p = e.ptr + e.stride[0];
            run.push_back('{p, 1'b0});
            n++;
            e.ptr = p;
            e.sent = e.sent + 1;
          end
        end else if ((stride == e.stride[c] && e.count < e.rep[c]) ||
                     (stride == e.trans[c] && e.count == e.rep[c])) begin
          if (e.count == e.rep[c]) begin
            e.count = 0; e.cur = ~e.cur;
          end else begin
            e.count = bump(e.count);
          end
          for (int i = 0; i < lim && e.sent < distance; i++) begin
            if (n >= room) break;
            walk(e, p);
            run.push_back('{p, 1'b0});
            n++;
            e.sent = e.sent + 1;
          end
        end else begin
          wipe(e);
        end
      end
      if (n > 0) run[n-1].last = 1;
      foreach (run[k]) want.push_back(run[k]);
      ent[r] = e;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_prefetch(logic [IDX_W-1:0] line, logic last);
      pf_t w;
      if (want.size() == 0) begin
        report($sformatf("unexpected prefetch line %h last %0d", line, last));
      end else begin
        w = want.pop_front();
        if (line !== w.line)
          report($sformatf("prefetch_line %h, predicted %h", line, w.line));
        if (last !== w.last)
          report($sformatf("last_of_run %0d, predicted %0d for line %h", last, w.last,
                           w.line));
      end
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  in_valid = 0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     line_address = '0;
  logic                  was_hit = 0;
  logic [TS_W-1:0]       time_stamp = '0;
  logic [ROOM_W-1:0]     queue_room = '0;
  logic                  out_valid;
  logic                  out_ready = 0;
  logic [IDX_W-1:0]      prefetch_line;
  logic                  last_of_run;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  prefetch_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int stall_cycles = 0;
  logic [TS_W-1:0] ts_now = 0;

  // access streams: base line, first stride, second stride, repeat length
  logic [IDX_W-1:0] st_line[4], st_a[4], st_b[4];
  int st_ra[4], st_pos[4], st_left[4];
  bit st_two[4], st_fresh[4];

  region_multi_stride_prefetcher dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // prefetch transfers are checked here
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_prefetch(prefetch_line, last_of_run);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= 5000) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  // receiver: random stalls and one long hold-off
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  task send_access(logic [ADDR_W-1:0] addr, logic hit, logic [TS_W-1:0] ts,
                   logic [ROOM_W-1:0] room);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    line_address <= addr;
    was_hit <= hit;
    time_stamp <= ts;
    queue_room <= room;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(addr, hit, ts, room);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // wait for every predicted prefetch, then for the longest access latency
  task drain;
    in_valid <= 0;
    @(posedge clk);
    while (sb.want.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task set_regs(int st, int mt, int sd, int dg, int ds, int so);
    write_reg(REG_SINGLE_THR, CFG_DATA_W'(st));
    write_reg(REG_MULTI_THR, CFG_DATA_W'(mt));
    write_reg(REG_START_DIST, CFG_DATA_W'(sd));
    write_reg(REG_DEGREE, CFG_DATA_W'(dg));
    write_reg(REG_DISTANCE, CFG_DATA_W'(ds));
    write_reg(REG_SINGLE_ONLY, CFG_DATA_W'(so));
  endtask

  function logic [IDX_W-1:0] pick_stride();
    logic [IDX_W-1:0] s;
    s = $urandom_range(1, 3);
    return ($urandom_range(0, 3) == 0) ? -s : s;
  endfunction

  function void new_stream(int k);
    st_line[k] = {$urandom(), $urandom()};
    st_a[k] = pick_stride();
    st_b[k] = pick_stride();
    if (st_b[k] == st_a[k]) st_b[k] = st_a[k] + 1;
    st_ra[k] = $urandom_range(1, 3);
    st_two[k] = $urandom_range(0, 1);
    st_pos[k] = 0;
    st_left[k] = $urandom_range(10, 24);
    st_fresh[k] = 1;
  endfunction

  function logic [TS_W-1:0] next_ts();
    ts_now = ts_now + $urandom_range(1, 5);
    return ($urandom_range(0, 15) == 0) ? $urandom() : ts_now;
  endfunction

  function logic [ROOM_W-1:0] pick_room();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 16;
  endfunction

  // mostly interleaved stride streams, the rest random noise
  task random_items(int count);
    int k;
    logic [IDX_W-1:0] s;
    logic hit;
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_access({$urandom(), $urandom()}, $urandom_range(0, 1), next_ts(), pick_room());
      end else begin
        k = $urandom_range(0, 3);
        if (st_left[k] == 0) new_stream(k);
        if (st_two[k] && st_pos[k] == st_ra[k]) begin
          s = st_b[k]; st_pos[k] = 0;
        end else begin
          s = st_a[k]; st_pos[k]++;
        end
        if (!st_fresh[k]) st_line[k] = st_line[k] + s;
        hit = st_fresh[k] ? 1'b0 : ($urandom_range(0, 7) != 0);
        st_fresh[k] = 0;
        st_left[k]--;
        send_access({st_line[k], 6'($urandom())}, hit, next_ts(), pick_room());
      end
    end
  endtask

  initial begin
    for (int k = 0; k < 4; k++) st_left[k] = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: address extremes, ignored hits, short trained runs, room limits
    send_access('0, 0, 0, 16);
    send_access({ADDR_W{1'b1}}, 0, {TS_W{1'b1}}, 0);
    send_access(48'h1234_5678_9000, 1, 5, 16);
    for (int i = 1; i <= 7; i++)
      send_access(48'(i * 64), 1, 10 + i, (i == 6) ? 0 : 16);
    for (int i = 0; i < 11; i++)
      send_access(48'h0000_0004_0000 + 48'((i + i / 2) * 64), i != 0, 20 + i, 16);
    send_access({ADDR_W{1'b1}} - 48'd64, 1, 40, 3);
    drain();

    // out-of-range indexes are ignored
    write_reg(3'd6, 8'hFF);
    write_reg(3'd7, 8'h01);
    random_items(40);
    drain();

    set_regs(1, 1, 0, 1, 1, 0);
    random_items(35);
    drain();

    // high-water settings with a long receiver hold-off
    set_regs(255, 255, 63, 16, 63, 1);
    set_regs(2, 3, 63, 16, 63, 0);
    hold_req = 1;
    random_items(45);
    drain();

    // zero thresholds, zero degree and distance
    set_regs(0, 0, 5, 0, 0, 0);
    random_items(15);
    drain();
    set_regs(0, 2, 2, 31, 8, 1);
    random_items(20);
    drain();

    // closing part with no idling
    set_regs(3, 2, 3, 8, 40, 0);
    quiet = 1;
    random_items(35);
    drain();

    foreach (sb.want[k])
      sb.report($sformatf("predicted line %h never arrived", sb.want[k].line));
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
